/* rtl/divh_pkg.sv */
// Shared constants, opcodes and the arctangent step table of the divergence histogram.
`default_nettype none
package divh_pkg;

  localparam int BINS_Y = 64;
  localparam int BINS_Z = 64;
  localparam int NBINS  = BINS_Y * BINS_Z;
  localparam int ADDR_W = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int BY_W   = (BINS_Y > 1) ? $clog2(BINS_Y) : 1;
  localparam int BZ_W   = (BINS_Z > 1) ? $clog2(BINS_Z) : 1;
  localparam int QW     = (BY_W > BZ_W) ? ((BY_W > 2) ? BY_W : 2) : ((BZ_W > 2) ? BZ_W : 2);
  localparam int DV_W   = 38;
  localparam int ANG_W  = 26;
  localparam int CORDIC_N = 23;
  localparam int SQRT_N   = 32;

  localparam logic signed [ANG_W-1:0] DEG90  = 26'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
  localparam logic [63:0] ONE_Q16 = 64'd65536;

  localparam logic [1:0] OP_EVENT  = 2'd0;
  localparam logic [1:0] OP_MARKER = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] REG_DIV_Y_MIN = 3'd0;
  localparam logic [2:0] REG_DIV_Y_MAX = 3'd1;
  localparam logic [2:0] REG_DIV_Z_MIN = 3'd2;
  localparam logic [2:0] REG_DIV_Z_MAX = 3'd3;
  localparam logic [2:0] REG_WL_WIN    = 3'd4;
  localparam logic [2:0] REG_POS_Y_WIN = 3'd5;
  localparam logic [2:0] REG_POS_Z_WIN = 3'd6;
  localparam logic [2:0] REG_MODE      = 3'd7;

  function automatic logic [22:0] atan_tab(input logic [4:0] i);
    logic [22:0] r;
    unique case (i)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/divergence_histogram_2d_top.sv */
// Two-dimensional divergence histogram: gating, angle unit, binning and bin memory.
//
// Usage: items enter on the in channel (in_valid_i / in_stall_o) and each gives one
// result beat on the out channel (out_valid_o / out_stall_i). An item is taken at an
// edge with valid high and stall low. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), to be written only while the block is idle; the
// block itself does not enforce this. One item is worked on at a time. An event that
// passes the windows and lands in a bin goes through three squarings on one 32x32
// multiplier, then per angle a normalize step, 32 square-root steps and 23 CORDIC
// steps, then a binning step, one restoring-division step per index bit for each
// axis, and a read-modify-write of the bin memory (registered read); one that misses
// every bin skips the division and the memory update. After reset the bin memory is
// cleared one entry per cycle, all 4096 entries, with in_stall_o high. The result
// sits in an output register; a stalled receiver holds it, and the block may take
// and work on the next item meanwhile, waiting only when its next result is ready.
`default_nettype none
module divergence_histogram_2d_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic signed [31:0] dir_x_i,
  input  wire logic signed [31:0] dir_y_i,
  input  wire logic signed [31:0] dir_z_i,
  input  wire logic [30:0] wavelength_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [31:0] weight_i,
  input  wire logic [5:0]  read_bin_y_i,
  input  wire logic [5:0]  read_bin_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             forward_o,
  output logic             registered_o,
  output logic [5:0]       bin_y_o,
  output logic [5:0]       bin_z_o,
  output logic [31:0]      bin_count_o,
  output logic [63:0]      bin_intensity_o,
  output logic [31:0]      total_count_o,
  output logic [63:0]      total_intensity_o,
  output logic [31:0]      bunch_count_o
);
  import divh_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_NORM = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_CORD = 4'd5;
  localparam logic [3:0] S_BIN  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // configuration
  logic signed [24:0] ymin_q, ymax_q, zmin_q, zmax_q;
  logic [63:0] wl_win_q, py_win_q, pz_win_q;
  logic [1:0]  mode_q;

  // control
  logic [3:0]  state_q;
  logic [4:0]  cnt_q;
  logic        axis_q;
  logic [ADDR_W:0] clr_q;

  // item
  logic [1:0]  op_q;
  logic signed [31:0] vx_q, vy_q, vz_q;
  logic [31:0] w_q;

  // angle unit
  logic [63:0] sq_q [3];
  logic [63:0] rad_q, bit_q;
  logic signed [63:0] cx_q, cy_q;
  logic signed [ANG_W-1:0] cz_q;
  logic        zero_q;
  logic signed [ANG_W-1:0] ang_y_q, ang_z_q;

  // divider
  logic [DV_W-1:0] rem_q, dq_q;
  logic [QW-1:0]   qt_q;
  logic [BY_W-1:0] iy_q;
  logic [DV_W-1:0] remz_q, dqz_q;

  // memory
  logic [95:0] mem_q [NBINS];
  logic [95:0] rdata_q;
  logic [ADDR_W-1:0] addr_q;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [95:0] mem_wd;

  // totals and staged result
  logic [31:0] tot_cnt_q, bunch_q;
  logic [63:0] tot_w_q;
  logic        fwd_q, reg_q;
  logic [5:0]  by_q, bz_q;
  logic [31:0] bc_q;
  logic [63:0] bi_q;

  logic accept;
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // gating
  logic gate_pass;
  always_comb begin
    logic signed [31:0] wmin, wmax, wlx;
    wmin = $signed(wl_win_q[31:0]);
    wmax = $signed(wl_win_q[63:32]);
    wlx  = $signed({1'b0, wavelength_i});
    gate_pass = 1'b1;
    if (!wmin[31] && (wlx < wmin)) gate_pass = 1'b0;
    if (!wmax[31] && (wlx > wmax)) gate_pass = 1'b0;
    if ((pos_y_i < $signed(py_win_q[31:0])) || (pos_y_i > $signed(py_win_q[63:32])))
      gate_pass = 1'b0;
    if ((pos_z_i < $signed(pz_win_q[31:0])) || (pos_z_i > $signed(pz_win_q[63:32])))
      gate_pass = 1'b0;
  end

  // squaring
  logic [31:0] mul_a;
  logic [63:0] prod;
  always_comb begin
    logic signed [31:0] v;
    case (cnt_q[1:0])
      2'd0:    v = vx_q;
      2'd1:    v = vy_q;
      default: v = vz_q;
    endcase
    mul_a = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
  end
  assign prod = mul_a * mul_a;

  // normalize
  logic [63:0] ns;
  logic [31:0] na;
  logic [4:0]  nh;
  always_comb begin
    logic signed [31:0] v;
    ns = axis_q ? (sq_q[0] + sq_q[1]) : (sq_q[0] + sq_q[2]);
    v  = axis_q ? vz_q : vy_q;
    na = v[31] ? (32'd0 - $unsigned(v)) : $unsigned(v);
    nh = 5'd0;
    for (int k = 1; k <= 24; k++) begin
      if ((ns >> (64 - 2 * k)) == 64'd0) nh = 5'(k);
    end
  end

  // square root step
  logic [63:0] sr_trial, sr_rad, sr_res;
  always_comb begin
    sr_trial = $unsigned(cx_q) + bit_q;
    if (rad_q >= sr_trial) begin
      sr_rad = rad_q - sr_trial;
      sr_res = ($unsigned(cx_q) >> 1) + bit_q;
    end else begin
      sr_rad = rad_q;
      sr_res = $unsigned(cx_q) >> 1;
    end
  end

  // CORDIC step
  logic signed [63:0] cx_n, cy_n, dxs, dys;
  logic signed [ANG_W-1:0] cz_n, at, ang_c, ang_s;
  always_comb begin
    dxs = cy_q >>> cnt_q;
    dys = cx_q >>> cnt_q;
    at  = $signed({3'b000, atan_tab(cnt_q)});
    if (!cy_q[63]) begin
      cx_n = cx_q + dxs;
      cy_n = cy_q - dys;
      cz_n = cz_q + at;
    end else begin
      cx_n = cx_q - dxs;
      cy_n = cy_q + dys;
      cz_n = cz_q - at;
    end
    if (zero_q || cz_n[ANG_W-1]) ang_c = '0;
    else if (cz_n > DEG90)       ang_c = DEG90;
    else                         ang_c = cz_n;
    if (!axis_q) begin
      if (!vx_q[31]) ang_s = vy_q[31] ? -ang_c : ang_c;
      else           ang_s = vy_q[31] ? (ang_c - DEG180) : (DEG180 - ang_c);
    end else begin
      ang_s = vz_q[31] ? -ang_c : ang_c;
    end
  end

  // binning
  logic signed [ANG_W-1:0] dyv, dzv, spy, spz;
  logic ok_y, ok_z;
  always_comb begin
    dyv  = ang_y_q - ANG_W'(ymin_q);
    dzv  = ang_z_q - ANG_W'(zmin_q);
    spy  = ANG_W'(ymax_q) - ANG_W'(ymin_q);
    spz  = ANG_W'(zmax_q) - ANG_W'(zmin_q);
    ok_y = (spy > 0) && !dyv[ANG_W-1] && (dyv < spy);
    ok_z = (spz > 0) && !dzv[ANG_W-1] && (dzv < spz);
  end

  // division step
  logic qbit;
  logic [DV_W-1:0] rem_n;
  logic [QW-1:0]   qt_n;
  always_comb begin
    qbit  = (rem_q >= dq_q);
    rem_n = qbit ? (rem_q - dq_q) : rem_q;
    qt_n  = {qt_q[QW-2:0], qbit};
  end

  // bin update
  logic [31:0] upd_cnt;
  logic [63:0] upd_w, w64;
  assign w64     = mode_q[0] ? {32'd0, w_q} : ONE_Q16;
  assign upd_cnt = (rdata_q[31:0] == '1) ? rdata_q[31:0] : rdata_q[31:0] + 32'd1;
  assign upd_w   = (rdata_q[95:32] > ~w64) ? '1 : rdata_q[95:32] + w64;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = {upd_w, upd_cnt};
    if (state_q == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_q[ADDR_W-1:0];
      mem_wd = '0;
    end else if (state_q == S_WR && op_q == OP_EVENT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[addr_q];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ymin_q   <= '0;
      ymax_q   <= '0;
      zmin_q   <= '0;
      zmax_q   <= '0;
      wl_win_q <= '1;
      py_win_q <= 64'h7FFF_FFFF_8000_0000;
      pz_win_q <= 64'h7FFF_FFFF_8000_0000;
      mode_q   <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DIV_Y_MIN: ymin_q   <= cfg_data_i[24:0];
        REG_DIV_Y_MAX: ymax_q   <= cfg_data_i[24:0];
        REG_DIV_Z_MIN: zmin_q   <= cfg_data_i[24:0];
        REG_DIV_Z_MAX: zmax_q   <= cfg_data_i[24:0];
        REG_WL_WIN:    wl_win_q <= cfg_data_i;
        REG_POS_Y_WIN: py_win_q <= cfg_data_i;
        REG_POS_Z_WIN: pz_win_q <= cfg_data_i;
        REG_MODE:      mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // datapath (no reset)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      vx_q   <= dir_x_i;
      vy_q   <= dir_y_i;
      vz_q   <= dir_z_i;
      w_q    <= weight_i;
      fwd_q  <= (opcode_i == OP_MARKER) ||
                ((opcode_i == OP_EVENT) && !mode_q[1]);
      reg_q  <= 1'b0;
      by_q   <= (opcode_i == OP_READ) ? read_bin_y_i : 6'd0;
      bz_q   <= (opcode_i == OP_READ) ? read_bin_z_i : 6'd0;
      bc_q   <= '0;
      bi_q   <= '0;
      addr_q <= ADDR_W'(int'(read_bin_y_i) * BINS_Z + int'(read_bin_z_i));
    end
    unique case (state_q)
      S_SQ: sq_q[cnt_q[1:0]] <= prod;
      S_NORM: begin
        zero_q <= (ns == 64'd0) && (na == 32'd0);
        rad_q  <= ns << (2 * nh);
        bit_q  <= 64'd1 << 62;
        cx_q   <= '0;
        cy_q   <= $signed({32'd0, na} << nh);
        cz_q   <= '0;
      end
      S_SQRT: begin
        rad_q <= sr_rad;
        cx_q  <= $signed(sr_res);
        bit_q <= bit_q >> 2;
      end
      S_CORD: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        if (cnt_q == 5'(CORDIC_N - 1)) begin
          if (axis_q) ang_z_q <= ang_s;
          else        ang_y_q <= ang_s;
        end
      end
      S_BIN: begin
        rem_q  <= DV_W'($unsigned(dyv)) * DV_W'(BINS_Y);
        dq_q   <= DV_W'($unsigned(spy)) << (BY_W - 1);
        remz_q <= DV_W'($unsigned(dzv)) * DV_W'(BINS_Z);
        dqz_q  <= DV_W'($unsigned(spz)) << (BZ_W - 1);
        qt_q   <= '0;
      end
      S_DIV: begin
        rem_q <= rem_n;
        dq_q  <= dq_q >> 1;
        qt_q  <= qt_n;
        if (!axis_q && cnt_q == 5'(BY_W - 1)) begin
          iy_q  <= qt_n[BY_W-1:0];
          rem_q <= remz_q;
          dq_q  <= dqz_q;
          qt_q  <= '0;
        end else if (axis_q && cnt_q == 5'(BZ_W - 1)) begin
          addr_q <= ADDR_W'(int'(iy_q) * BINS_Z + int'(qt_n[BZ_W-1:0]));
          by_q   <= 6'(iy_q);
          bz_q   <= 6'(qt_n[BZ_W-1:0]);
        end
      end
      S_WR: begin
        if (op_q == OP_EVENT) begin
          reg_q <= 1'b1;
          fwd_q <= 1'b1;
          bc_q  <= upd_cnt;
          bi_q  <= upd_w;
        end else begin
          bc_q  <= rdata_q[31:0];
          bi_q  <= rdata_q[95:32];
        end
      end
      default: ;
    endcase
  end

  // control, totals and output register
  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      clr_q       <= '0;
      tot_cnt_q   <= '0;
      tot_w_q     <= '0;
      bunch_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (ADDR_W+1)'(NBINS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cnt_q  <= '0;
            axis_q <= 1'b0;
            case (opcode_i)
              OP_EVENT:  state_q <= gate_pass ? S_SQ : S_OUT;
              OP_MARKER: begin
                if (bunch_q != '1) bunch_q <= bunch_q + 32'd1;
                state_q <= S_OUT;
              end
              OP_READ: state_q <= ((int'(read_bin_y_i) < BINS_Y) &&
                                   (int'(read_bin_z_i) < BINS_Z)) ? S_RD : S_OUT;
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd2) state_q <= S_NORM;
        end
        S_NORM: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(SQRT_N - 1)) begin
            cnt_q   <= '0;
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(CORDIC_N - 1)) begin
            cnt_q   <= '0;
            axis_q  <= ~axis_q;
            state_q <= axis_q ? S_BIN : S_NORM;
          end
        end
        S_BIN: begin
          cnt_q   <= '0;
          axis_q  <= 1'b0;
          state_q <= (ok_y && ok_z) ? S_DIV : S_OUT;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (!axis_q && cnt_q == 5'(BY_W - 1)) begin
            cnt_q  <= '0;
            axis_q <= 1'b1;
          end else if (axis_q && cnt_q == 5'(BZ_W - 1)) begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if (op_q == OP_EVENT) begin
            if (tot_cnt_q != '1) tot_cnt_q <= tot_cnt_q + 32'd1;
            tot_w_q <= (tot_w_q > ~w64) ? '1 : tot_w_q + w64;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      forward_o         <= fwd_q;
      registered_o      <= reg_q;
      bin_y_o           <= by_q;
      bin_z_o           <= bz_q;
      bin_count_o       <= bc_q;
      bin_intensity_o   <= bi_q;
      total_count_o     <= tot_cnt_q;
      total_intensity_o <= tot_w_q;
      bunch_count_o     <= bunch_q;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/divergence_histogram_2d_top_tb.sv */
// Self-checking testbench for the divergence histogram: queued stimulus, predictor, beat checker.
module divergence_histogram_2d_top_tb;
  import divh_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam longint ANG_STEP [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
  localparam longint ANG90  = 5898240;
  localparam longint ANG180 = 11796480;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] dx, dy, dz;
    logic [30:0]        wl;
    logic signed [31:0] py, pz;
    logic [31:0]        wt;
    logic [5:0]         ry, rz;
  } particle_t;

  typedef struct packed {
    logic        fwd, hit;
    logic [5:0]  by, bz;
    logic [31:0] bc;
    logic [63:0] bi;
    logic [31:0] tc;
    logic [63:0] ti;
    logic [31:0] nb;
  } hist_beat_t;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_idx = REG_DIV_Y_MIN;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  particle_t cur = '0;
  logic in_stall_o, out_valid_o, forward_o, registered_o;
  logic [5:0] bin_y_o, bin_z_o;
  logic [31:0] bin_count_o, total_count_o, bunch_count_o;
  logic [63:0] bin_intensity_o, total_intensity_o;

  divergence_histogram_2d_top i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o,
    .opcode_i(cur.op), .dir_x_i(cur.dx), .dir_y_i(cur.dy), .dir_z_i(cur.dz),
    .wavelength_i(cur.wl), .pos_y_i(cur.py), .pos_z_i(cur.pz), .weight_i(cur.wt),
    .read_bin_y_i(cur.ry), .read_bin_z_i(cur.rz),
    .out_valid_o, .out_stall_i(out_stall),
    .forward_o, .registered_o, .bin_y_o, .bin_z_o, .bin_count_o, .bin_intensity_o,
    .total_count_o, .total_intensity_o, .bunch_count_o
  );

  initial forever #5 clk_i = ~clk_i;

  // predictor state
  longint ymin, ymax, zmin, zmax;
  logic [63:0] wl_win, py_win, pz_win;
  logic [1:0] mode;
  int unsigned hist_cnt [NBINS];
  longint unsigned hist_wt [NBINS];
  int unsigned hit_total, bunches;
  longint unsigned wt_total;

  particle_t  pend_q [$];
  hist_beat_t exp_q [$];
  int hit_bins [$];
  int errors = 0;
  int taken_cnt = 0, sent_cnt = 0;
  int hold_req = 0;
  bit accepted_any;

  function automatic longint div_angle(longint unsigned s, longint unsigned a);
    int h;
    longint unsigned t, r, b;
    longint x, y, z, sx, sy;
    if (s == 0 && a == 0) return 0;
    h = 24;
    while (h > 0 && (s >> (64 - 2 * h)) != 0) h--;
    t = s << (2 * h);
    r = 0;
    b = 64'h1 << 62;
    while (b > t) b >>= 2;
    while (b != 0) begin
      if (t >= r + b) begin
        t -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    x = r;
    y = a << h;
    z = 0;
    for (int i = 0; i < 23; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y >= 0) begin
        x += sx; y -= sy; z += ANG_STEP[i];
      end else begin
        x -= sx; y += sy; z -= ANG_STEP[i];
      end
    end
    if (z < 0) z = 0;
    if (z > ANG90) z = ANG90;
    return z;
  endfunction

  function automatic bit div_bin(longint ang, longint lo, longint hi, longint nbins,
                                 output longint idx);
    longint span, d, q;
    span = hi - lo;
    d = ang - lo;
    idx = 0;
    if (span <= 0 || d < 0) return 0;
    q = (nbins * d) / span;
    if (q >= nbins) return 0;
    idx = q;
    return 1;
  endfunction

  function automatic hist_beat_t histogram_update(particle_t p);
    hist_beat_t r;
    longint ax, ay, az, a, ang_y, ang_z, iy, iz, wmin, wmax;
    longint unsigned w;
    int k;
    bit pass;
    r = '0;
    if (p.op == OP_EVENT) begin
      wmin = longint'($signed(wl_win[31:0]));
      wmax = longint'($signed(wl_win[63:32]));
      r.fwd = !mode[1];
      pass = 1;
      if (wmin >= 0 && longint'(p.wl) < wmin) pass = 0;
      if (wmax >= 0 && longint'(p.wl) > wmax) pass = 0;
      if (p.py < $signed(py_win[31:0]) || p.py > $signed(py_win[63:32])) pass = 0;
      if (p.pz < $signed(pz_win[31:0]) || p.pz > $signed(pz_win[63:32])) pass = 0;
      if (pass) begin
        ax = longint'(p.dx); if (ax < 0) ax = -ax;
        ay = longint'(p.dy); if (ay < 0) ay = -ay;
        az = longint'(p.dz); if (az < 0) az = -az;
        w = mode[0] ? longint'(p.wt) : 65536;
        a = div_angle(ax * ax + az * az, ay);
        if (p.dx >= 0) ang_y = (p.dy < 0) ? -a : a;
        else ang_y = (p.dy >= 0) ? ANG180 - a : -ANG180 + a;
        a = div_angle(ax * ax + ay * ay, az);
        ang_z = (p.dz < 0) ? -a : a;
        if (div_bin(ang_y, ymin, ymax, BINS_Y, iy) && div_bin(ang_z, zmin, zmax, BINS_Z, iz))
        begin
          k = int'(iy * BINS_Z + iz);
          if (hist_cnt[k] != '1) hist_cnt[k]++;
          if (hit_total != '1) hit_total++;
          hist_wt[k] = (hist_wt[k] > ~w) ? '1 : hist_wt[k] + w;
          wt_total = (wt_total > ~w) ? '1 : wt_total + w;
          r.hit = 1;
          r.fwd = 1;
          r.by = iy[5:0];
          r.bz = iz[5:0];
          r.bc = hist_cnt[k];
          r.bi = hist_wt[k];
          hit_bins.push_back(k);
          if (hit_bins.size() > 64) void'(hit_bins.pop_front());
        end
      end
    end else if (p.op == OP_MARKER) begin
      if (bunches != '1) bunches++;
      r.fwd = 1;
    end else if (p.op == OP_READ) begin
      r.by = p.ry;
      r.bz = p.rz;
      if (p.ry < BINS_Y && p.rz < BINS_Z) begin
        k = int'(p.ry) * BINS_Z + int'(p.rz);
        r.bc = hist_cnt[k];
        r.bi = hist_wt[k];
      end
    end
    r.tc = hit_total;
    r.ti = wt_total;
    r.nb = bunches;
    return r;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
    @(negedge clk_i);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= d;
    case (idx)
      REG_DIV_Y_MIN: ymin = longint'($signed(d[24:0]));
      REG_DIV_Y_MAX: ymax = longint'($signed(d[24:0]));
      REG_DIV_Z_MIN: zmin = longint'($signed(d[24:0]));
      REG_DIV_Z_MAX: zmax = longint'($signed(d[24:0]));
      REG_WL_WIN:    wl_win = d;
      REG_POS_Y_WIN: py_win = d;
      REG_POS_Z_WIN: pz_win = d;
      REG_MODE:      mode = d[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 0;
  endtask

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || exp_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic [63:0] angle_reg(longint v);
    logic [63:0] r;
    r = 64'(v);
    r[63:25] = 39'($urandom);
    return r;
  endfunction

  function automatic longint rnd_angle();
    case ($urandom_range(0, 3))
      0: return -ANG180;
      1: return ANG180;
      default: return longint'($urandom_range(0, 2 * ANG180)) - ANG180;
    endcase
  endfunction

  task automatic all_open(logic [1:0] m);
    cfg_write(REG_DIV_Y_MIN, angle_reg(-ANG180));
    cfg_write(REG_DIV_Y_MAX, angle_reg(ANG180));
    cfg_write(REG_DIV_Z_MIN, angle_reg(-ANG90));
    cfg_write(REG_DIV_Z_MAX, angle_reg(ANG90));
    cfg_write(REG_WL_WIN, '1);
    cfg_write(REG_POS_Y_WIN, 64'h7FFFFFFF_80000000);
    cfg_write(REG_POS_Z_WIN, 64'h7FFFFFFF_80000000);
    cfg_write(REG_MODE, {62'($urandom), m});
  endtask

  function automatic logic [63:0] rnd_window(bit wide);
    int lo, hi, t;
    if (wide) return 64'h7FFFFFFF_80000000;
    lo = $urandom;
    hi = $urandom;
    if ($urandom_range(0, 3) != 0 && lo > hi) begin
      t = lo; lo = hi; hi = t;
    end
    if ($urandom_range(0, 1)) begin
      lo = lo >>> $urandom_range(4, 16);
      hi = hi >>> $urandom_range(4, 16);
      if (lo > hi) begin
        t = lo; lo = hi; hi = t;
      end
    end
    return {hi, lo};
  endfunction

  task automatic rnd_config();
    longint a, b, t;
    bit narrow;
    narrow = $urandom_range(0, 2) == 0;
    a = narrow ? rnd_angle() : -ANG180;
    b = narrow ? rnd_angle() : ANG180;
    if (a > b && $urandom_range(0, 4) != 0) begin
      t = a; a = b; b = t;
    end
    cfg_write(REG_DIV_Y_MIN, angle_reg(a));
    cfg_write(REG_DIV_Y_MAX, angle_reg(b));
    a = narrow ? rnd_angle() : -ANG90;
    b = narrow ? rnd_angle() : ANG90;
    if (a > b && $urandom_range(0, 4) != 0) begin
      t = a; a = b; b = t;
    end
    cfg_write(REG_DIV_Z_MIN, angle_reg(a));
    cfg_write(REG_DIV_Z_MAX, angle_reg(b));
    cfg_write(REG_WL_WIN, $urandom_range(0, 1) ? 64'(rnd_window(0)) : {$urandom, $urandom});
    cfg_write(REG_POS_Y_WIN, rnd_window($urandom_range(0, 2) != 0));
    cfg_write(REG_POS_Z_WIN, rnd_window($urandom_range(0, 2) != 0));
    cfg_write(REG_MODE, {62'($urandom), 2'($urandom)});
  endtask

  function automatic logic [31:0] rnd_dir(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return 32'd0;
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic particle_t rnd_particle();
    particle_t p;
    int k;
    p = '0;
    p.dx = $urandom; p.dy = $urandom; p.dz = $urandom;
    p.wl = 31'($urandom); p.py = $urandom; p.pz = $urandom; p.wt = $urandom;
    p.ry = 6'($urandom); p.rz = 6'($urandom);
    k = $urandom_range(0, 99);
    if (k < 68) begin
      p.op = OP_EVENT;
      if ($urandom_range(0, 1)) begin
        p.dx = 32'($urandom_range(1 << 20, 1 << 30));
        p.dy = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        p.dz = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        if ($urandom_range(0, 3) == 0) p.dx = -p.dx;
      end else begin
        p.dx = rnd_dir($urandom_range(0, 3));
        p.dy = rnd_dir($urandom_range(0, 3));
        p.dz = rnd_dir($urandom_range(0, 3));
      end
      if ($urandom_range(0, 2) == 0) p.wl = 31'($urandom_range(0, 1 << 20));
      if ($urandom_range(0, 2) == 0) p.py = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      if ($urandom_range(0, 2) == 0) p.pz = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    end else if (k < 78) p.op = OP_MARKER;
    else if (k < 96) begin
      p.op = OP_READ;
      if (hit_bins.size() != 0 && $urandom_range(0, 1)) begin
        k = hit_bins[$urandom_range(0, hit_bins.size() - 1)];
        p.ry = 6'(k / BINS_Z);
        p.rz = 6'(k % BINS_Z);
      end
    end else p.op = OP_NONE;
    return p;
  endfunction

  function automatic particle_t mk(logic [1:0] op, logic [31:0] dx, logic [31:0] dy,
                                   logic [31:0] dz, logic [31:0] wt);
    particle_t p;
    p = '0;
    p.op = op; p.dx = dx; p.dy = dy; p.dz = dz; p.wt = wt;
    p.wl = 31'h0001_0000;
    return p;
  endfunction

  // driver: bursts and gaps, payload held until taken
  int burst_left = 4, gap_left = 0;
  always @(negedge clk_i) begin
    bit live;
    if (in_valid && taken_cnt != sent_cnt) begin
      sent_cnt++;
      live = 0;
    end else live = in_valid;
    if (!live && rst_ni) begin
      if (gap_left > 0) gap_left--;
      else if (pend_q.size() != 0) begin
        cur <= pend_q.pop_front();
        live = 1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0, 1: gap_left = 0;
            2: gap_left = $urandom_range(1, 6);
            default: gap_left = $urandom_range(7, 200);
          endcase
        end
      end
    end
    in_valid <= live;
  end

  // receiver stall patterns
  int stall_mode = 0, mode_left = 0, hold_left = 0, hold_seen = 0;
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen++;
      hold_left = 600;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(64, 512);
      stall_mode = $urandom_range(0, 3);
    end else mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= (mode_left % 4) != 0;
      default: out_stall <= $urandom_range(0, 9) == 0;
    endcase
  end

  // accept monitor and checker
  always @(posedge clk_i) begin
    hist_beat_t got, want;
    accepted_any = 0;
    if (rst_ni && in_valid && !in_stall_o) begin
      exp_q.push_back(histogram_update(cur));
      taken_cnt++;
      accepted_any = 1;
    end
    if (rst_ni && out_valid_o && !out_stall) begin
      accepted_any = 1;
      got = {forward_o, registered_o, bin_y_o, bin_z_o, bin_count_o, bin_intensity_o,
             total_count_o, total_intensity_o, bunch_count_o};
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = exp_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %h got %h", want, got);
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    #1;
    if (accepted_any) idle_cycles = 0;
    else if (++idle_cycles >= WDOG_LIMIT) begin
      $display("divergence_histogram_2d_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    particle_t p;
    ymin = 0; ymax = 0; zmin = 0; zmax = 0;
    wl_win = '1; py_win = 64'h7FFFFFFF_80000000; pz_win = 64'h7FFFFFFF_80000000;
    mode = 2'd1;
    foreach (hist_cnt[i]) begin
      hist_cnt[i] = 0;
      hist_wt[i] = 0;
    end
    hit_total = 0; wt_total = 0; bunches = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1;

    // reset settings: zero spans register nothing
    pend_q.push_back(mk(OP_EVENT, 32'h10000, 0, 0, 32'hFFFF_FFFF));
    pend_q.push_back(mk(OP_MARKER, 0, 0, 0, 0));
    pend_q.push_back(mk(OP_READ, 0, 0, 0, 0));
    drain();

    all_open(2'd1);
    pend_q.push_back(mk(OP_EVENT, 0, 0, 0, 32'h0001_0000));
    pend_q.push_back(mk(OP_EVENT, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    pend_q.push_back(mk(OP_EVENT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
    pend_q.push_back(mk(OP_EVENT, 32'h8000_0000, 32'h0010_0000, 32'hFFF0_0000, 0));
    pend_q.push_back(mk(OP_EVENT, 32'hFFFF_0000, 0, 32'h7FFF_FFFF, 32'h1234_5678));
    pend_q.push_back(mk(OP_EVENT, 0, 32'h7FFF_FFFF, 0, 5));
    pend_q.push_back(mk(OP_EVENT, 0, 32'h8000_0000, 0, 5));
    pend_q.push_back(mk(OP_EVENT, 1, 1, 1, 1));
    pend_q.push_back(mk(OP_EVENT, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    p = mk(OP_EVENT, 32'h10000, 0, 0, 7);
    p.wl = '1; p.py = 32'h7FFF_FFFF; p.pz = 32'h8000_0000;
    pend_q.push_back(p);
    pend_q.push_back(mk(OP_MARKER, 0, 0, 0, 0));
    pend_q.push_back(mk(OP_NONE, 0, 0, 0, 0));
    p = mk(OP_READ, 0, 0, 0, 0); p.ry = 6'd63; p.rz = 6'd63; pend_q.push_back(p);
    p = mk(OP_READ, 0, 0, 0, 0); p.ry = 6'd63; p.rz = 6'd32; pend_q.push_back(p);
    p = mk(OP_READ, 0, 0, 0, 0); p.ry = 6'd32; p.rz = 6'd32; pend_q.push_back(p);
    drain();

    // wavelength window and weight-one forward-only mode
    all_open(2'd2);
    cfg_write(REG_WL_WIN, {32'h0000_2000, 32'h0000_1000});
    p = mk(OP_EVENT, 32'h10000, 0, 0, 9); p.wl = 31'h0FFF; pend_q.push_back(p);
    p.wl = 31'h1000; pend_q.push_back(p);
    p.wl = 31'h2001; pend_q.push_back(p);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) all_open(2'd3);
      else rnd_config();
      for (int n = 0; n < 250; n++) pend_q.push_back(rnd_particle());
      if (ph == 1 || ph == 4) begin
        while (pend_q.size() > 200) @(negedge clk_i);
        hold_req++;
      end
      drain();
    end

    all_open(2'd0);
    for (int n = 0; n < 50; n++) pend_q.push_back(rnd_particle());
    drain();

    if (errors == 0 && exp_q.size() == 0)
      $display("divergence_histogram_2d_top_tb: done, clean");
    else
      $display("divergence_histogram_2d_top_tb: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/divh_pkg.sv
rtl/divergence_histogram_2d_top.sv
tb/sv/divergence_histogram_2d_top_tb.sv
